/* hdl/assert_macros.svh */
// assertion helpers for the gradient descent block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHECK_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("check failed");
// next-cycle implication
`define CHECK_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("check failed");
`endif

/* hdl/lgd_pkg.sv */
// ----------------------------------------------------------------------------
// lgd_pkg
// shared types and constants for the gradient descent block
// ----------------------------------------------------------------------------
`default_nettype none
package lgd_pkg;
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 16;
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        OP_FEAT = 2'd0,
        OP_TGT  = 2'd1,
        OP_WGT  = 2'd2,
        OP_ITER = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_STEP = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  index;
        logic [63:0] value;
        logic        last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_PRED, S_PRED_ACC, S_RES, S_GRAD, S_GRAD_ACC,
        S_CDIV, S_COST_OUT, S_UPD_MUL, S_UPD_DIV, S_UPD_OUT
    } st_t;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return I64_MAX;
        if (a[63] && b[63] && !s[63]) return I64_MIN;
        return s;
    endfunction
endpackage
`default_nettype wire

/* hdl/lgd_fifo.sv */
// ----------------------------------------------------------------------------
// lgd_fifo
// small synchronous queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module lgd_fifo
    import lgd_pkg::*;
#(
    parameter int W = 8,
    parameter int D = QDEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         rd,
    output logic [W-1:0]      rdata,
    output logic              empty
);
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    logic [W-1:0] mem [D];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(D));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full) mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= (wp_reg == AW'(D-1)) ? '0 : wp_reg + 1'b1;
            if (rd && !empty)
                rp_reg <= (rp_reg == AW'(D-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
        end
    end
endmodule
`default_nettype wire

/* hdl/lgd_div.sv */
// ----------------------------------------------------------------------------
// lgd_div
// unsigned 64 by 13 bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module lgd_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [12:0] den,
    output logic             done,
    output logic [63:0]      quo
);
    logic [63:0] q_reg;
    logic [13:0] rem_reg;
    logic [12:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [13:0] trial;

    assign trial = {rem_reg[12:0], q_reg[63]};
    assign quo  = q_reg;
    assign done = busy_reg && (cnt_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'd64;
        end
        else if (busy_reg && cnt_reg != 7'd0)
            cnt_reg <= cnt_reg - 1'b1;
        else
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/lgd_core.sv */
// ----------------------------------------------------------------------------
// lgd_core
// back end: stores, multiply-accumulate sequencer and weight update
// ----------------------------------------------------------------------------
`default_nettype none
module lgd_core
    import lgd_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] step_size,
    input  wire logic [12:0] m_cnt,
    input  wire logic [6:0]  n_cnt,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_take,
    output logic             res_valid,
    output res_t             res,
    input  wire logic        res_full,
    output logic             busy
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [31:0] fmem [MAX_ROWS*MAX_COLS];
    logic [31:0] tmem [MAX_ROWS];
    logic [31:0] wmem [MAX_COLS];
    logic [63:0] gacc [MAX_COLS];

    st_t st_reg, st_next;
    logic [12:0] i_reg, i_next;
    logic [6:0]  j_reg, j_next;
    logic [31:0] f_rd_reg, t_rd_reg, w_rd_reg;
    logic [63:0] h_reg, r_reg, cost_reg, prod_reg;
    logic        neg_reg;
    logic        cost_sat_reg;

    // store reads are addressed with the next indices so the registered data
    // matches the current indices
    logic [RW-1:0] ri;
    logic [CW-1:0] cj, cj_nx;
    assign ri = i_next[RW-1:0];
    assign cj = j_reg[CW-1:0];
    assign cj_nx = j_next[CW-1:0];

    // divider shared by cost and step divide
    logic        dv_start, dv_done;
    logic [63:0] dv_num, dv_quo;
    logic [12:0] dv_den;
    lgd_div u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                   .done(dv_done), .quo(dv_quo));

    logic cmd_ok;
    logic [31:0] crow;
    logic [31:0] ccol;
    assign crow = 32'(cmd.row);
    assign ccol = 32'(cmd.col);
    assign cmd_ok = cmd_valid && st_reg == S_IDLE;
    assign cmd_take = cmd_ok;
    assign busy = st_reg != S_IDLE;

    // loads
    always_ff @(posedge clk)
    begin
        if (cmd_ok && cmd.op == OP_FEAT && 32'(crow) < 32'(MAX_ROWS)
            && 32'(ccol) < 32'(MAX_COLS))
            fmem[(RW+CW)'(crow) * (RW+CW)'(MAX_COLS) + (RW+CW)'(ccol)] <= cmd.value;
        if (cmd_ok && cmd.op == OP_TGT && 32'(crow) < 32'(MAX_ROWS))
            tmem[RW'(crow)] <= cmd.value;
        f_rd_reg <= fmem[(RW+CW)'(ri) * (RW+CW)'(MAX_COLS) + (RW+CW)'(cj_nx)];
        t_rd_reg <= tmem[ri];
        w_rd_reg <= wmem[cj_nx];
    end

    // products
    logic signed [63:0] fw_p, rf_mag;
    logic [63:0] rmag, fmag;
    logic [95:0] rf_full;
    assign fw_p = $signed(f_rd_reg) * $signed(w_rd_reg);
    assign rmag = r_reg[63] ? -r_reg : r_reg;
    assign fmag = f_rd_reg[31] ? 64'(-$signed({32'hFFFFFFFF, f_rd_reg})) :
                  {32'd0, f_rd_reg};
    // gradient term magnitude, bounded multiply 64x32 in two halves over a stage
    logic [63:0] gm_lo, gm_hi;
    assign gm_lo = 64'(rmag[31:0]) * 64'(fmag[31:0]);
    assign gm_hi = 64'(rmag[63:32]) * 64'(fmag[31:0]);
    assign rf_full = 96'(gm_lo) + {gm_hi, 32'd0};
    logic gneg;
    assign gneg = r_reg[63] ^ f_rd_reg[31];
    always_comb
    begin
        if (gneg)
            rf_mag = (rf_full > {32'd0, I64_MIN}) ? $signed(I64_MIN) :
                     -$signed(rf_full[63:0]);
        else
            rf_mag = (rf_full > {32'd0, I64_MAX}) ? $signed(I64_MAX) :
                     $signed(rf_full[63:0]);
    end

    logic [63:0] gabs;
    assign gabs = gacc[cj][63] ? -gacc[cj] : gacc[cj];
    logic signed [63:0] wnew;
    // squared residual is only used when the magnitude fits in 32 bits
    logic [63:0] sq;
    assign sq = 64'(rmag[31:0]) * 64'(rmag[31:0]);

    // step before the divide by the row count
    logic [63:0] stp_hi, stp_lo;
    assign stp_hi = 64'(gabs[63:32]) * 64'(step_size);
    assign stp_lo = 64'(gabs[31:0]) * 64'(step_size);

    always_comb
    begin
        st_next = st_reg;
        i_next = i_reg;
        j_next = j_reg;
        dv_start = 1'b0;
        dv_num = cost_reg;
        dv_den = {m_cnt[11:0], 1'b0};
        res_valid = 1'b0;
        res = '0;
        wnew = $signed({{32{w_rd_reg[31]}}, w_rd_reg}) -
               (neg_reg ? -$signed(dv_quo) : $signed(dv_quo));
        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd_ok && cmd.op == OP_ITER)
                begin
                    st_next = S_CLR;
                    i_next = '0;
                    j_next = '0;
                end
            end
            S_CLR:
            begin
                st_next = S_PRED;
                j_next = '0;
            end
            S_PRED: st_next = S_PRED_ACC;
            S_PRED_ACC:
            begin
                if (j_reg + 1'b1 == n_cnt)
                begin
                    st_next = S_RES;
                    j_next = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    st_next = S_PRED;
                end
            end
            S_RES: st_next = S_GRAD;
            S_GRAD: st_next = S_GRAD_ACC;
            S_GRAD_ACC:
            begin
                if (j_reg + 1'b1 == n_cnt)
                begin
                    j_next = '0;
                    if (i_reg + 1'b1 == m_cnt)
                    begin
                        st_next = S_CDIV;
                        dv_start = 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        st_next = S_PRED;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    st_next = S_GRAD;
                end
            end
            S_CDIV: if (dv_done) st_next = S_COST_OUT;
            S_COST_OUT:
            begin
                res_valid = 1'b1;
                res.kind = 1'b0;
                res.value = cost_sat_reg ? I64_MAX : dv_quo;
                if (!res_full)
                begin
                    st_next = S_UPD_MUL;
                    j_next = '0;
                end
            end
            S_UPD_MUL:
            begin
                dv_start = 1'b1;
                dv_num = stp_hi + (stp_lo >> 32);
                dv_den = m_cnt;
                st_next = S_UPD_DIV;
            end
            S_UPD_DIV: if (dv_done) st_next = S_UPD_OUT;
            S_UPD_OUT:
            begin
                res_valid = 1'b1;
                res.kind = 1'b1;
                res.index = 4'(j_reg);
                res.last = (j_reg + 1'b1 == n_cnt);
                if (wnew > 64'sh7FFFFFFF) res.value = 64'h7FFFFFFF;
                else if (wnew < -64'sh80000000) res.value = 64'hFFFFFFFF80000000;
                else res.value = wnew;
                if (!res_full)
                begin
                    if (j_reg + 1'b1 == n_cnt)
                        st_next = S_IDLE;
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        st_next = S_UPD_MUL;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_ok && cmd.op == OP_WGT && 32'(ccol) < 32'(MAX_COLS))
            wmem[CW'(ccol)] <= cmd.value;
        unique case (st_reg)
            S_CLR:
            begin
                cost_reg <= '0;
                cost_sat_reg <= 1'b0;
                h_reg <= '0;
                for (int k = 0; k < MAX_COLS; k++) gacc[k] <= '0;
            end
            S_PRED_ACC:
                h_reg <= $signed(h_reg) + (fw_p >>> 16);
            S_RES:
            begin
                r_reg <= h_reg - 64'($signed(t_rd_reg));
                h_reg <= '0;
            end
            S_GRAD:
            begin
                if (j_reg == '0)
                begin
                    if (rmag > 64'd3037000499)
                    begin
                        cost_reg <= I64_MAX;
                        cost_sat_reg <= 1'b1;
                    end
                    else
                    begin
                        cost_reg <= sat_add64(cost_reg, sq);
                        cost_sat_reg <= (sat_add64(cost_reg, sq) == I64_MAX);
                    end
                end
                prod_reg <= rf_mag;
            end
            S_GRAD_ACC:
                gacc[cj] <= sat_add64(gacc[cj], prod_reg);
            S_COST_OUT, S_UPD_OUT:
            begin
                neg_reg <= gacc[CW'(j_next)][63];
                if (st_reg == S_UPD_OUT && !res_full)
                    wmem[cj] <= res.value[31:0];
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/linreg_gradient_descent.sv */
// load items pass through the command queue into the stores; iterate: for each
// sample row a prediction pass and a gradient pass over the features, then a
// shared bit-serial 64-bit divider for the cost and for each weight step
// results leave through a result queue; loads are taken back to back while idle
// rst_n asynchronous active low clears control; stores hold junk until written
`default_nettype none
module linreg_gradient_descent
    import lgd_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  row,
    input  wire logic [3:0]  col,
    input  wire logic signed [31:0] value,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic [3:0]       index,
    output logic signed [63:0] result_value,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    `include "assert_macros.svh"

    // config registers
    logic [15:0] step_reg;
    logic [8:0]  rows_reg;
    logic [4:0]  cols_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 16'd655;
            rows_reg <= 9'd256;
            cols_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP: step_reg <= cfg_data;
                CFG_ROWS: rows_reg <= cfg_data[8:0];
                CFG_COLS: cols_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp counts: zero acts as one, large saturates to the store size
    logic [12:0] m_cnt;
    logic [6:0]  n_cnt;
    always_comb
    begin
        m_cnt = (rows_reg == '0) ? 13'd1 :
                (32'(rows_reg) > MAX_ROWS) ? 13'(MAX_ROWS) : 13'(rows_reg);
        n_cnt = (cols_reg == '0) ? 7'd1 :
                (32'(cols_reg) > MAX_COLS) ? 7'(MAX_COLS) : 7'(cols_reg);
    end

    // front: command queue
    cmd_t cin, cq;
    logic cq_empty, cq_take;
    assign cin = '{op: op_t'(op), row: row, col: col, value: value};
    lgd_fifo #(.W($bits(cmd_t))) u_cq (
        .clk, .rst_n, .wr(push), .wdata(cin), .full(full),
        .rd(cq_take), .rdata(cq), .empty(cq_empty));

    // back: core and result queue
    logic res_valid, rq_full, core_busy;
    res_t res, rq;
    lgd_core #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_core (
        .clk, .rst_n, .step_size(step_reg), .m_cnt, .n_cnt,
        .cmd_valid(!cq_empty), .cmd(cq), .cmd_take(cq_take),
        .res_valid, .res, .res_full(rq_full), .busy(core_busy));

    lgd_fifo #(.W($bits(res_t))) u_rq (
        .clk, .rst_n, .wr(res_valid), .wdata(res), .full(rq_full),
        .rd(pop), .rdata(rq), .empty(empty));

    assign kind = rq.kind;
    assign index = rq.index;
    assign result_value = rq.value;
    assign last = rq.last;

    `CHECK_IMPL(a_take_idle, clk, rst_n, cq_take, !cq_empty)
    `CHECK_IMPL(a_res_kind, clk, rst_n, res_valid && !res.kind, !res.last)
    `CHECK_NEXT(a_busy_start, clk, rst_n, cq_take && cq.op == OP_ITER, core_busy)
endmodule
`default_nettype wire

/* test/linreg_gradient_descent_tb.sv */
// ----------------------------------------------------------------------------
// linreg_gradient_descent_tb
// self-checking bench for the batch gradient descent block: loads matrices,
// runs iterations and compares every cost and weight transfer with a model
// ----------------------------------------------------------------------------
`default_nettype none
module linreg_gradient_descent_tb;
    import lgd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = 256;
    localparam int NCOLS = 16;
    localparam int WATCHDOG_LIMIT = 200000;
    // settle time that covers the block's tail
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [127:0] W64_MAX = 128'sd9223372036854775807;
    localparam logic signed [127:0] W64_MIN = -W64_MAX - 128'sd1;
    localparam longint L64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  op = OP_FEAT;
    logic [7:0]  row = '0;
    logic [3:0]  col = '0;
    logic signed [31:0] value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        kind;
    logic [3:0]  index;
    logic signed [63:0] result_value;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_STEP;
    logic [15:0] cfg_data = '0;

    linreg_gradient_descent u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op), .row(row),
        .col(col), .value(value), .empty(empty), .pop(pop), .kind(kind),
        .index(index), .result_value(result_value), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of the block's state
    logic signed [31:0] feat_mem [NROWS][NCOLS];
    logic signed [31:0] tgt_mem [NROWS];
    logic signed [31:0] wgt_mem [NCOLS];
    bit                 feat_ok [NROWS][NCOLS];
    bit                 tgt_ok [NROWS];
    bit                 wgt_ok [NCOLS];
    logic [15:0]        alpha_q = 16'd655;
    logic [8:0]         rows_q = 9'd256;
    logic [4:0]         cols_q = 5'd16;

    res_t expected_q [$];
    int   fail_count = 0;
    int   item_count = 0;

    function automatic longint clamp64(input logic signed [127:0] v);
        if (v > W64_MAX) return L64_MAX;
        if (v < W64_MIN) return -L64_MAX - 1;
        return longint'(v);
    endfunction

    function automatic int rows_eff();
        if (rows_q == 0) return 1;
        return (rows_q > NROWS) ? NROWS : int'(rows_q);
    endfunction

    function automatic int cols_eff();
        if (cols_q == 0) return 1;
        return (cols_q > NCOLS) ? NCOLS : int'(cols_q);
    endfunction

    // one full-batch step: queue the cost, then every updated weight
    task automatic predict_iteration();
        int m, n;
        longint h, r, cost, s, w;
        longint grad [NCOLS];
        logic [63:0] mr, gm, stp;
        res_t res;
        m = rows_eff();
        n = cols_eff();
        cost = 0;
        for (int j = 0; j < NCOLS; j++) grad[j] = 0;
        for (int i = 0; i < m; i++)
        begin
            h = 0;
            for (int j = 0; j < n; j++)
                h += (longint'(feat_mem[i][j]) * longint'(wgt_mem[j])) >>> 16;
            r = h - longint'(tgt_mem[i]);
            mr = (r < 0) ? 64'(-r) : 64'(r);
            if (mr > 64'd3037000499)
                cost = L64_MAX;
            else
                cost = clamp64(128'(cost) + $signed({64'd0, mr * mr}));
            for (int j = 0; j < n; j++)
                grad[j] = clamp64(128'(grad[j]) +
                    128'(clamp64(128'(r) * 128'(longint'(feat_mem[i][j])))));
        end
        res.kind = 1'b0;
        res.index = '0;
        res.value = (cost == L64_MAX) ? cost : cost / longint'(2 * m);
        res.last = 1'b0;
        expected_q.push_back(res);
        for (int j = 0; j < n; j++)
        begin
            gm = grad[j][63] ? (64'd0 - grad[j]) : grad[j];
            stp = (gm >> 32) * alpha_q + (((gm & 64'hFFFF_FFFF) * alpha_q) >> 32);
            stp = stp / m;
            s = (grad[j] < 0) ? -longint'(stp) : longint'(stp);
            w = longint'(wgt_mem[j]) - s;
            if (w > 64'sd2147483647) w = 64'sd2147483647;
            if (w < -64'sd2147483648) w = -64'sd2147483648;
            wgt_mem[j] = w[31:0];
            res.kind = 1'b1;
            res.index = j[3:0];
            res.value = w;
            res.last = (j + 1 == n);
            expected_q.push_back(res);
        end
    endtask

    // one input transfer; called and returns at a falling edge
    task automatic send_item(input op_t o, input int r, input int c, input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        op <= o;
        row <= r[7:0];
        col <= c[3:0];
        value <= v;
        @(posedge clk);
        while (full) @(posedge clk);
        item_count++;
        case (o)
            OP_FEAT: begin feat_mem[r][c] = v; feat_ok[r][c] = 1; end
            OP_TGT:  begin tgt_mem[r] = v; tgt_ok[r] = 1; end
            OP_WGT:  begin wgt_mem[c] = v; wgt_ok[c] = 1; end
            default: predict_iteration();
        endcase
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        // loads leave no result, so give the block time to settle
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] d);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEP: alpha_q = d;
            CFG_ROWS: rows_q = d[8:0];
            CFG_COLS: cols_q = d[4:0];
            default: ;
        endcase
    endtask

    // mostly small q16.16 numbers, some full range, some extremes
    function automatic logic [31:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // fill every entry the current sizes read, so no unwritten entry is used
    task automatic load_active(input bit fresh);
        for (int i = 0; i < rows_eff(); i++)
        begin
            for (int j = 0; j < cols_eff(); j++)
                if (fresh || !feat_ok[i][j]) send_item(OP_FEAT, i, j, rand_value());
            if (fresh || !tgt_ok[i]) send_item(OP_TGT, i, 0, rand_value());
        end
        for (int j = 0; j < cols_eff(); j++)
            if (fresh || !wgt_ok[j]) send_item(OP_WGT, 0, j, rand_value());
    endtask

    // extremes of the values, saturation of cost, gradient and weights,
    // zero counts, zero and full step size, the unused register index
    task automatic test_directed();
        cfg_write(CFG_STEP, 16'hFFFF);
        cfg_write(CFG_ROWS, 9'd2);
        cfg_write(CFG_COLS, 5'd2);
        cfg_write(CFG_UNUSED, 16'hFFFF);
        send_item(OP_FEAT, 0, 0, 32'h7FFF_FFFF);
        send_item(OP_FEAT, 0, 1, 32'h8000_0000);
        send_item(OP_FEAT, 1, 0, 32'h0001_0000);
        send_item(OP_FEAT, 1, 1, 32'hFFFF_0000);
        send_item(OP_TGT, 0, 0, 32'h8000_0000);
        send_item(OP_TGT, 1, 0, 32'h7FFF_FFFF);
        send_item(OP_WGT, 0, 0, 32'h7FFF_FFFF);
        send_item(OP_WGT, 0, 1, 32'h8000_0000);
        send_item(OP_ITER, 0, 0, 32'h0);
        send_item(OP_ITER, 255, 15, 32'hFFFF_FFFF);
        // small well-behaved step
        send_item(OP_FEAT, 0, 0, 32'h0001_0000);
        send_item(OP_FEAT, 0, 1, 32'h0002_0000);
        send_item(OP_TGT, 0, 0, 32'h0003_0000);
        send_item(OP_WGT, 0, 0, 32'h0);
        send_item(OP_WGT, 0, 1, 32'h0);
        send_item(OP_ITER, 0, 0, 32'h0);
        cfg_write(CFG_STEP, 16'h0);
        send_item(OP_ITER, 0, 0, 32'h0);
        // zero counts behave as one
        cfg_write(CFG_ROWS, 9'd0);
        cfg_write(CFG_COLS, 5'd0);
        cfg_write(CFG_STEP, 16'd655);
        send_item(OP_ITER, 0, 0, 32'h0);
    endtask

    // column count above the store saturates to all sixteen columns
    task automatic test_wide_row();
        cfg_write(CFG_ROWS, 9'd1);
        cfg_write(CFG_COLS, 5'd31);
        load_active(1'b1);
        send_item(OP_ITER, 0, 0, 32'h0);
        send_item(OP_ITER, 0, 0, 32'h0);
    endtask

    // row count above the store saturates to every sample, one column
    task automatic test_tall();
        cfg_write(CFG_COLS, 5'd1);
        cfg_write(CFG_ROWS, 9'h1FF);
        load_active(1'b0);
        send_item(OP_ITER, 0, 0, 32'h0);
        cfg_write(CFG_ROWS, 9'd256);
        send_item(OP_ITER, 0, 0, 32'h0);
    endtask

    // random phases: new sizes, fresh data, then loads mixed with iterations
    task automatic test_random();
        int burst;
        while (item_count < 660)
        begin
            cfg_write(CFG_STEP, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
            cfg_write(CFG_ROWS, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                                             : $urandom_range(1, 6)));
            cfg_write(CFG_COLS, 16'($urandom_range(0, 31)));
            if (rows_eff() > 8) cfg_write(CFG_ROWS, 16'($urandom_range(1, 8)));
            load_active(1'b1);
            burst = $urandom_range(5, 30);
            for (int k = 0; k < burst; k++)
            begin
                if ($urandom_range(0, 9) < 3)
                    send_item(OP_ITER, $urandom_range(0, 255), $urandom_range(0, 15), $urandom);
                else
                    send_item(op_t'($urandom_range(0, 2)), $urandom_range(0, rows_eff() - 1),
                              $urandom_range(0, cols_eff() - 1), rand_value());
            end
        end
    endtask

    // result side: random stall, then check each popped transfer
    initial
    begin
        int stall;
        res_t exp_res;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 11);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer kind=%0d index=%0d value=%0d",
                       kind, index, result_value);
                fail_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (kind !== exp_res.kind)
                begin
                    $error("kind expected %0d actual %0d", exp_res.kind, kind);
                    fail_count++;
                end
                if (index !== exp_res.index)
                begin
                    $error("index expected %0d actual %0d", exp_res.index, index);
                    fail_count++;
                end
                if (result_value !== exp_res.value)
                begin
                    $error("result_value expected %0d actual %0d",
                           $signed(exp_res.value), result_value);
                    fail_count++;
                end
                if (last !== exp_res.last)
                begin
                    $error("last expected %0d actual %0d", exp_res.last, last);
                    fail_count++;
                end
            end
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_wide_row();
        test_tall();
        test_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/lgd_pkg.sv
hdl/lgd_fifo.sv
hdl/lgd_div.sv
hdl/lgd_core.sv
hdl/linreg_gradient_descent.sv
test/linreg_gradient_descent_tb.sv
